/* rtl/z80bs_pkg.sv */
// shared types and opcode constants for the z80 branch and stack unit
// used by every module of the block; depends on nothing
`default_nettype none

package z80bs_pkg;

  // opcode groups selected by the low three opcode bits
  localparam logic [2:0] GRP_RET_CC  = 3'd0;
  localparam logic [2:0] GRP_POP_MSC = 3'd1;
  localparam logic [2:0] GRP_JP_CC   = 3'd2;
  localparam logic [2:0] GRP_JP_MSC  = 3'd3;
  localparam logic [2:0] GRP_CALL_CC = 3'd4;
  localparam logic [2:0] GRP_PUSH    = 3'd5;
  localparam logic [2:0] GRP_ALU_IMM = 3'd6;
  localparam logic [2:0] GRP_RST     = 3'd7;

  // single opcodes
  localparam logic [7:0] OP_JP       = 8'hC3;
  localparam logic [7:0] OP_RET      = 8'hC9;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_EXX      = 8'hD9;
  localparam logic [7:0] OP_EX_SP_HL = 8'hE3;
  localparam logic [7:0] OP_JP_HL    = 8'hE9;
  localparam logic [7:0] OP_EX_DE_HL = 8'hEB;
  localparam logic [7:0] OP_DI       = 8'hF3;
  localparam logic [7:0] OP_LD_SP_HL = 8'hF9;
  localparam logic [7:0] OP_EI       = 8'hFB;

  // register pair selector, opcode bits 5..4
  localparam logic [1:0] RP_BC = 2'd0;
  localparam logic [1:0] RP_DE = 2'd1;
  localparam logic [1:0] RP_HL = 2'd2;
  localparam logic [1:0] RP_AF = 2'd3;

  // flag tested by a condition, opcode bits 5..4
  localparam logic [1:0] CF_ZERO   = 2'd0;
  localparam logic [1:0] CF_CARRY  = 2'd1;
  localparam logic [1:0] CF_PARITY = 2'd2;
  localparam logic [1:0] CF_SIGN   = 2'd3;

  // architectural state
  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] bc_alt;
    logic [15:0] de_alt;
    logic [15:0] hl_alt;
    logic        iff1;
    logic        iff2;
  } cpu_state_t;

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic        unhandled;
    logic        taken;
    logic [4:0]  tstates;
    logic [15:0] write_data;
    logic [15:0] write_addr;
    logic        write_enable;
    logic [15:0] next_sp;
    logic [15:0] next_pc;
  } exec_result_t;

endpackage

`default_nettype wire

/* rtl/z80_branch_stack_unit_core.sv */
// top level of the z80 branch and stack unit: input register, execute, result register
// depends on z80bs_pkg, z80bs_regfile and z80bs_exec
`default_nettype none

// Executes one Z80 control-transfer or stack opcode (0xC0..0xFF) per item and
// returns the next PC and SP, an optional 16-bit stack write, the T-state
// count and the taken and unhandled flags. Items pass an input register,
// combinational decode and execute against the internal register file, and a
// result register; with the output side ready one item is accepted every
// cycle. The register file is
// updated as each item executes, so items are applied strictly in order.
// Opcodes below 0xC0, the immediate ALU, IN, OUT and prefix bytes come back
// flagged unhandled with no state change. Reset clears the register file and the valid flags.

module z80_branch_stack_unit_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // imm_word[15:0], stack_word[31:16]
  input  wire logic [7:0]  in_tuser,   // kind[7:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // next_pc[15:0], next_sp[31:16], write_enable[32], write_addr[48:33],
  // write_data[64:49], tstates[69:65], taken[70], unhandled[71]
  output logic [71:0]      out_tdata
);

  logic        in_valid_r;
  logic [7:0]  in_kind_r;
  logic [15:0] in_imm_r;
  logic [15:0] in_stk_r;
  logic        out_valid_r;
  logic        advance;

  z80bs_pkg::cpu_state_t   state;
  z80bs_pkg::cpu_state_t   state_nxt;
  z80bs_pkg::exec_result_t res;
  z80bs_pkg::exec_result_t out_data_r;

  // an item moves to the result register when that register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= in_tuser;
      in_imm_r  <= in_tdata[15:0];
      in_stk_r  <= in_tdata[31:16];
    end
  end

  // register file
  z80bs_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (advance),
    .state_nxt (state_nxt),
    .state     (state)
  );

  // execute
  z80bs_exec u_exec (
    .op        (in_kind_r),
    .imm       (in_imm_r),
    .stk       (in_stk_r),
    .state     (state),
    .state_nxt (state_nxt),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* rtl/z80bs_regfile.sv */
// architectural register file: pc, sp, pairs, shadow pairs, interrupt flags
// depends on z80bs_pkg
`default_nettype none

module z80bs_regfile (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  upd_en,
  input  wire z80bs_pkg::cpu_state_t state_nxt,
  output z80bs_pkg::cpu_state_t      state
);

  z80bs_pkg::cpu_state_t state_r;

  // commit the new state when an item executes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (upd_en) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

`default_nettype wire

/* rtl/z80bs_exec.sv */
// instruction decode and execute for opcodes 0xc0..0xff, purely combinational
// depends on z80bs_pkg
`default_nettype none

module z80bs_exec (
  input  wire logic [7:0]            op,
  input  wire logic [15:0]           imm,
  input  wire logic [15:0]           stk,
  input  wire z80bs_pkg::cpu_state_t state,
  output z80bs_pkg::cpu_state_t      state_nxt,
  output z80bs_pkg::exec_result_t    res
);

  logic [15:0] pc1;
  logic [15:0] pc3;
  logic [15:0] sp_inc;
  logic [15:0] sp_dec;
  logic [1:0]  rp;
  logic        flag_bit;
  logic        cond;
  logic        unh;
  z80bs_pkg::cpu_state_t  s_nxt;
  z80bs_pkg::exec_result_t r;

  assign pc1    = state.pc + 16'd1;
  assign pc3    = state.pc + 16'd3;
  assign sp_inc = state.sp + 16'd2;
  assign sp_dec = state.sp - 16'd2;
  assign rp     = op[5:4];

  // condition code: bits 5..4 pick the flag, bit 3 the polarity
  always_comb begin
    case (op[5:4])
      z80bs_pkg::CF_ZERO:   flag_bit = state.af[6];
      z80bs_pkg::CF_CARRY:  flag_bit = state.af[0];
      z80bs_pkg::CF_PARITY: flag_bit = state.af[2];
      z80bs_pkg::CF_SIGN:   flag_bit = state.af[7];
      default:              flag_bit = 1'b0;
    endcase
    cond = op[3] ? flag_bit : !flag_bit;
  end

  // main decode
  always_comb begin
    s_nxt   = state;
    r       = '0;
    r.next_pc = pc1;
    r.next_sp = state.sp;
    unh     = 1'b0;
    if (op[7:6] != 2'b11) begin
      unh = 1'b1;
    end else begin
      case (op[2:0])
        z80bs_pkg::GRP_RET_CC: begin
          if (cond) begin
            r.next_pc = stk;
            r.next_sp = sp_inc;
            r.tstates = 5'd11;
            r.taken   = 1'b1;
          end else begin
            r.tstates = 5'd5;
          end
        end
        z80bs_pkg::GRP_POP_MSC: begin
          if (!op[3]) begin
            case (rp)
              z80bs_pkg::RP_BC: s_nxt.bc = stk;
              z80bs_pkg::RP_DE: s_nxt.de = stk;
              z80bs_pkg::RP_HL: s_nxt.hl = stk;
              default:          s_nxt.af = stk;
            endcase
            r.next_sp = sp_inc;
            r.tstates = 5'd10;
          end else if (op == z80bs_pkg::OP_RET) begin
            r.next_pc = stk;
            r.next_sp = sp_inc;
            r.tstates = 5'd10;
          end else if (op == z80bs_pkg::OP_EXX) begin
            s_nxt.bc     = state.bc_alt;
            s_nxt.de     = state.de_alt;
            s_nxt.hl     = state.hl_alt;
            s_nxt.bc_alt = state.bc;
            s_nxt.de_alt = state.de;
            s_nxt.hl_alt = state.hl;
            r.tstates    = 5'd4;
          end else if (op == z80bs_pkg::OP_JP_HL) begin
            r.next_pc = state.hl;
            r.tstates = 5'd4;
          end else begin
            // ld sp,hl
            r.next_sp = state.hl;
            r.tstates = 5'd6;
          end
        end
        z80bs_pkg::GRP_JP_CC: begin
          r.next_pc = cond ? imm : pc3;
          r.taken   = cond;
          r.tstates = 5'd10;
        end
        z80bs_pkg::GRP_JP_MSC: begin
          if (op == z80bs_pkg::OP_JP) begin
            r.next_pc = imm;
            r.tstates = 5'd10;
          end else if (op == z80bs_pkg::OP_EX_SP_HL) begin
            r.write_enable = 1'b1;
            r.write_addr   = state.sp;
            r.write_data   = state.hl;
            s_nxt.hl       = stk;
            r.tstates      = 5'd19;
          end else if (op == z80bs_pkg::OP_EX_DE_HL) begin
            s_nxt.de  = state.hl;
            s_nxt.hl  = state.de;
            r.tstates = 5'd4;
          end else if (op == z80bs_pkg::OP_DI) begin
            s_nxt.iff1 = 1'b0;
            s_nxt.iff2 = 1'b0;
            r.tstates  = 5'd4;
          end else if (op == z80bs_pkg::OP_EI) begin
            s_nxt.iff1 = 1'b1;
            s_nxt.iff2 = 1'b1;
            r.tstates  = 5'd4;
          end else begin
            // out (n),a, in a,(n) and the cb prefix
            unh = 1'b1;
          end
        end
        z80bs_pkg::GRP_CALL_CC: begin
          if (cond) begin
            r.next_sp      = sp_dec;
            r.write_enable = 1'b1;
            r.write_addr   = sp_dec;
            r.write_data   = pc3;
            r.next_pc      = imm;
            r.tstates      = 5'd17;
            r.taken        = 1'b1;
          end else begin
            r.next_pc = pc3;
            r.tstates = 5'd10;
          end
        end
        z80bs_pkg::GRP_PUSH: begin
          if (!op[3]) begin
            r.next_sp      = sp_dec;
            r.write_enable = 1'b1;
            r.write_addr   = sp_dec;
            case (rp)
              z80bs_pkg::RP_BC: r.write_data = state.bc;
              z80bs_pkg::RP_DE: r.write_data = state.de;
              z80bs_pkg::RP_HL: r.write_data = state.hl;
              default:          r.write_data = state.af;
            endcase
            r.tstates = 5'd11;
          end else if (op == z80bs_pkg::OP_CALL) begin
            r.next_sp      = sp_dec;
            r.write_enable = 1'b1;
            r.write_addr   = sp_dec;
            r.write_data   = pc3;
            r.next_pc      = imm;
            r.tstates      = 5'd17;
          end else begin
            // prefix bytes
            unh = 1'b1;
          end
        end
        z80bs_pkg::GRP_ALU_IMM: begin
          unh = 1'b1;
        end
        default: begin
          // rst n: target is opcode bits 5..3 times eight
          r.next_sp      = sp_dec;
          r.write_enable = 1'b1;
          r.write_addr   = sp_dec;
          r.write_data   = pc1;
          r.next_pc      = {10'd0, op[5:3], 3'd0};
          r.tstates      = 5'd11;
        end
      endcase
    end

    // unhandled opcodes leave all state alone and report it unchanged
    if (unh) begin
      s_nxt       = state;
      r           = '0;
      r.next_pc   = state.pc;
      r.next_sp   = state.sp;
      r.unhandled = 1'b1;
    end else begin
      s_nxt.pc = r.next_pc;
      s_nxt.sp = r.next_sp;
    end
  end

  assign state_nxt = s_nxt;
  assign res       = r;

endmodule

`default_nettype wire

/* bench/tb.sv */
// self-checking bench for z80_branch_stack_unit_core: an in-bench copy of the
// architectural state predicts each result item; depends on z80bs_pkg and the core
`default_nettype none

module tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;

  // first opcode this unit executes, and the fixed top two opcode bits
  localparam logic [7:0] FIRST_HANDLED = 8'hC0;
  localparam logic [1:0] HI_QUAD       = 2'b11;

  // condition codes, opcode bits 5..3
  localparam logic [2:0] CC_NZ = 3'd0;
  localparam logic [2:0] CC_Z  = 3'd1;
  localparam logic [2:0] CC_NC = 3'd2;
  localparam logic [2:0] CC_C  = 3'd3;
  localparam logic [2:0] CC_PO = 3'd4;
  localparam logic [2:0] CC_PE = 3'd5;
  localparam logic [2:0] CC_P  = 3'd6;
  localparam logic [2:0] CC_M  = 3'd7;

  // restart vectors, opcode bits 5..3
  localparam logic [2:0] RST_FIRST = 3'd0;
  localparam logic [2:0] RST_LAST  = 3'd7;

  // opcodes this unit leaves alone
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_LAST_LOW  = 8'hBF;
  localparam logic [7:0] OP_OUT_N     = 8'hD3;
  localparam logic [7:0] OP_CP_N      = 8'hFE;
  localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
  localparam logic [7:0] OP_PREFIX_DD = 8'hDD;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // imm_word[15:0], stack_word[31:16]
  logic [7:0]  in_tuser = '0;   // kind[7:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // next_pc .. unhandled, see exec_result_t

  z80bs_pkg::cpu_state_t   arch;
  z80bs_pkg::exec_result_t pending_results[$];
  z80bs_pkg::exec_result_t got_item, want_item;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           hold_request = 0;
  bit           sender_calm = 1'b0;
  bit           receiver_calm = 1'b0;

  z80_branch_stack_unit_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // opcode builders
  function automatic logic [7:0] cond_op(input logic [2:0] grp, input logic [2:0] cc);
    return {HI_QUAD, cc, grp};
  endfunction

  function automatic logic [7:0] pair_op(input logic [2:0] grp, input logic [1:0] rp);
    return {HI_QUAD, rp, 1'b0, grp};
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // data word with extra weight on the extremes
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // condition test against F
  function automatic logic cond_met(input logic [2:0] cc);
    logic [7:0] f;
    logic       flag;
    f = arch.af[7:0];
    case (cc[2:1])
      z80bs_pkg::CF_ZERO:   flag = f[6];
      z80bs_pkg::CF_CARRY:  flag = f[0];
      z80bs_pkg::CF_PARITY: flag = f[2];
      default:              flag = f[7];
    endcase
    return cc[0] ? flag : !flag;
  endfunction

  // executes one opcode on the bench copy of the state and returns its result
  function automatic z80bs_pkg::exec_result_t execute_opcode(input logic [7:0] op,
                                                             input logic [15:0] imm,
                                                             input logic [15:0] stk);
    z80bs_pkg::exec_result_t r;
    logic [15:0]  pc_after, swap;
    logic [2:0]   cc;
    logic [1:0]   rp;
    logic         unh;
    pc_after = arch.pc + 16'd1;
    cc = op[5:3];
    rp = op[5:4];
    unh = 1'b0;
    r = '0;
    r.next_pc = pc_after;
    r.next_sp = arch.sp;
    if (op < FIRST_HANDLED) begin
      unh = 1'b1;
    end else begin
      case (op[2:0])
        z80bs_pkg::GRP_RET_CC: begin
          if (cond_met(cc)) begin
            r.next_pc = stk;
            r.next_sp = arch.sp + 16'd2;
            r.tstates = 5'd11;
            r.taken = 1'b1;
          end else begin
            r.tstates = 5'd5;
          end
        end
        z80bs_pkg::GRP_POP_MSC: begin
          if (!op[3]) begin
            case (rp)
              z80bs_pkg::RP_BC: arch.bc = stk;
              z80bs_pkg::RP_DE: arch.de = stk;
              z80bs_pkg::RP_HL: arch.hl = stk;
              default:          arch.af = stk;
            endcase
            r.next_sp = arch.sp + 16'd2;
            r.tstates = 5'd10;
          end else if (op == z80bs_pkg::OP_RET) begin
            r.next_pc = stk;
            r.next_sp = arch.sp + 16'd2;
            r.tstates = 5'd10;
          end else if (op == z80bs_pkg::OP_EXX) begin
            swap = arch.bc; arch.bc = arch.bc_alt; arch.bc_alt = swap;
            swap = arch.de; arch.de = arch.de_alt; arch.de_alt = swap;
            swap = arch.hl; arch.hl = arch.hl_alt; arch.hl_alt = swap;
            r.tstates = 5'd4;
          end else if (op == z80bs_pkg::OP_JP_HL) begin
            r.next_pc = arch.hl;
            r.tstates = 5'd4;
          end else begin
            r.next_sp = arch.hl;
            r.tstates = 5'd6;
          end
        end
        z80bs_pkg::GRP_JP_CC: begin
          if (cond_met(cc)) begin
            r.next_pc = imm;
            r.taken = 1'b1;
          end else begin
            r.next_pc = pc_after + 16'd2;
          end
          r.tstates = 5'd10;
        end
        z80bs_pkg::GRP_JP_MSC: begin
          if (op == z80bs_pkg::OP_JP) begin
            r.next_pc = imm;
            r.tstates = 5'd10;
          end else if (op == z80bs_pkg::OP_EX_SP_HL) begin
            r.write_enable = 1'b1;
            r.write_addr = arch.sp;
            r.write_data = arch.hl;
            arch.hl = stk;
            r.tstates = 5'd19;
          end else if (op == z80bs_pkg::OP_EX_DE_HL) begin
            swap = arch.de; arch.de = arch.hl; arch.hl = swap;
            r.tstates = 5'd4;
          end else if (op == z80bs_pkg::OP_DI) begin
            arch.iff1 = 1'b0;
            arch.iff2 = 1'b0;
            r.tstates = 5'd4;
          end else if (op == z80bs_pkg::OP_EI) begin
            arch.iff1 = 1'b1;
            arch.iff2 = 1'b1;
            r.tstates = 5'd4;
          end else begin
            unh = 1'b1;
          end
        end
        z80bs_pkg::GRP_CALL_CC: begin
          if (cond_met(cc)) begin
            r.next_sp = arch.sp - 16'd2;
            r.write_enable = 1'b1;
            r.write_addr = r.next_sp;
            r.write_data = pc_after + 16'd2;
            r.next_pc = imm;
            r.tstates = 5'd17;
            r.taken = 1'b1;
          end else begin
            r.next_pc = pc_after + 16'd2;
            r.tstates = 5'd10;
          end
        end
        z80bs_pkg::GRP_PUSH: begin
          if (!op[3]) begin
            r.next_sp = arch.sp - 16'd2;
            r.write_enable = 1'b1;
            r.write_addr = r.next_sp;
            case (rp)
              z80bs_pkg::RP_BC: r.write_data = arch.bc;
              z80bs_pkg::RP_DE: r.write_data = arch.de;
              z80bs_pkg::RP_HL: r.write_data = arch.hl;
              default:          r.write_data = arch.af;
            endcase
            r.tstates = 5'd11;
          end else if (op == z80bs_pkg::OP_CALL) begin
            r.next_sp = arch.sp - 16'd2;
            r.write_enable = 1'b1;
            r.write_addr = r.next_sp;
            r.write_data = pc_after + 16'd2;
            r.next_pc = imm;
            r.tstates = 5'd17;
          end else begin
            unh = 1'b1;
          end
        end
        z80bs_pkg::GRP_ALU_IMM: unh = 1'b1;
        default: begin
          // restart: push the return address, jump to the vector
          r.next_sp = arch.sp - 16'd2;
          r.write_enable = 1'b1;
          r.write_addr = r.next_sp;
          r.write_data = pc_after;
          r.next_pc = {10'd0, cc, 3'd0};
          r.tstates = 5'd11;
        end
      endcase
    end
    // left alone: state kept, everything else cleared
    if (unh) begin
      r = '0;
      r.next_pc = arch.pc;
      r.next_sp = arch.sp;
      r.unhandled = 1'b1;
    end
    arch.pc = r.next_pc;
    arch.sp = r.next_sp;
    return r;
  endfunction

  // sends one item; tvalid stays high after the accept for a following item
  task automatic send_item(input logic [7:0] op, input logic [15:0] imm,
                           input logic [15:0] stk);
    int gap;
    gap = pick_gap(sender_calm);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {stk, imm};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(execute_opcode(op, imm, stk));
  endtask

  // drops tvalid and waits until every expected item has come back
  task automatic wait_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one random instruction: mostly handled opcodes, some flag loads, some others
  task automatic send_random_item();
    int          r;
    logic [7:0]  op;
    r = $urandom_range(0, 99);
    if (r < 12) op = 8'($urandom);
    else if (r < 22) op = pair_op(z80bs_pkg::GRP_POP_MSC, z80bs_pkg::RP_AF);
    else op = {HI_QUAD, 6'($urandom)};
    send_item(op, pick_word(), pick_word());
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_item = z80bs_pkg::exec_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        $error("result item 0x%0h with none expected", out_tdata);
        mismatch_count++;
      end else begin
        want_item = pending_results.pop_front();
        compare_field("next_pc", want_item.next_pc, got_item.next_pc);
        compare_field("next_sp", want_item.next_sp, got_item.next_sp);
        compare_field("write_enable", 16'(want_item.write_enable),
                      16'(got_item.write_enable));
        compare_field("write_addr", want_item.write_addr, got_item.write_addr);
        compare_field("write_data", want_item.write_data, got_item.write_data);
        compare_field("tstates", 16'(want_item.tstates), 16'(got_item.tstates));
        compare_field("taken", 16'(want_item.taken), 16'(got_item.taken));
        compare_field("unhandled", 16'(want_item.unhandled), 16'(got_item.unhandled));
      end
    end
  end

  // receiver: random stalls, long hold on request, none when calm
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (receiver_calm) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = pick_gap(1'b0);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // every opcode family, condition polarities, wraps and left-alone opcodes
  task automatic test_directed();
    send_item(pair_op(z80bs_pkg::GRP_PUSH, z80bs_pkg::RP_BC), 16'h0000, 16'h0000);
    // sp wrapped below zero above; all flags set next
    send_item(pair_op(z80bs_pkg::GRP_POP_MSC, z80bs_pkg::RP_AF), 16'h0000, 16'hFFFF);
    send_item(cond_op(z80bs_pkg::GRP_RET_CC, CC_NZ), 16'h0000, 16'h1111);
    send_item(cond_op(z80bs_pkg::GRP_RET_CC, CC_Z), 16'h0000, 16'hFFFF);  // pc to top
    send_item(cond_op(z80bs_pkg::GRP_JP_CC, CC_NC), 16'h2222, 16'h0000);  // pc wraps
    send_item(cond_op(z80bs_pkg::GRP_JP_CC, CC_C), 16'hFFFF, 16'h0000);
    send_item(cond_op(z80bs_pkg::GRP_CALL_CC, CC_PO), 16'h3333, 16'h0000);
    send_item(cond_op(z80bs_pkg::GRP_CALL_CC, CC_PE), 16'h0000, 16'h0000);
    send_item(cond_op(z80bs_pkg::GRP_JP_CC, CC_M), 16'h8000, 16'h0000);
    // all flags clear
    send_item(pair_op(z80bs_pkg::GRP_POP_MSC, z80bs_pkg::RP_AF), 16'h0000, 16'h0000);
    send_item(cond_op(z80bs_pkg::GRP_RET_CC, CC_M), 16'h0000, 16'h4444);
    send_item(cond_op(z80bs_pkg::GRP_CALL_CC, CC_NZ), 16'h1234, 16'h0000);
    send_item(cond_op(z80bs_pkg::GRP_RET_CC, CC_P), 16'h0000, 16'hABCD);
    send_item(pair_op(z80bs_pkg::GRP_POP_MSC, z80bs_pkg::RP_HL), 16'h0000, 16'hA5A5);
    send_item(pair_op(z80bs_pkg::GRP_POP_MSC, z80bs_pkg::RP_DE), 16'h0000, 16'h5A5A);
    send_item(pair_op(z80bs_pkg::GRP_POP_MSC, z80bs_pkg::RP_BC), 16'h0000, 16'hFFFF);
    send_item(z80bs_pkg::OP_EX_DE_HL, 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_EXX, 16'h0000, 16'h0000);
    send_item(pair_op(z80bs_pkg::GRP_PUSH, z80bs_pkg::RP_HL), 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_EX_SP_HL, 16'h0000, 16'h0001);
    send_item(z80bs_pkg::OP_LD_SP_HL, 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_JP_HL, 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_DI, 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_EI, 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_JP, 16'hFFFF, 16'h0000);
    send_item(z80bs_pkg::OP_CALL, 16'h0000, 16'h0000);
    send_item(z80bs_pkg::OP_RET, 16'h0000, 16'h4000);
    send_item(cond_op(z80bs_pkg::GRP_RST, RST_LAST), 16'h0000, 16'h0000);
    send_item(cond_op(z80bs_pkg::GRP_RST, RST_FIRST), 16'h0000, 16'h0000);
    send_item(OP_NOP, 16'hFFFF, 16'hFFFF);
    send_item(OP_LAST_LOW, 16'h0000, 16'h0000);
    send_item(OP_CP_N, 16'h0000, 16'h0000);
    send_item(OP_OUT_N, 16'h0000, 16'h0000);
    send_item(OP_PREFIX_CB, 16'h0000, 16'h0000);
    send_item(OP_PREFIX_DD, 16'h0000, 16'h0000);
  endtask

  // random instruction stream with random idling on both sides
  task automatic test_random_stream(input int count);
    repeat (count) send_random_item();
  endtask

  // no idling on either side: one item per cycle
  task automatic test_back_to_back(input int count);
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    repeat (count) send_random_item();
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_hold(input int count);
    sender_calm = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (count) send_random_item();
    sender_calm = 1'b0;
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause(input int count);
    repeat (count) send_random_item();
    wait_drained();
    repeat (count) send_random_item();
  endtask

  initial begin
    arch = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    test_random_stream(RANDOM_ITEMS / 2);
    test_back_to_back(200);
    test_output_hold(40);
    test_drain_pause(50);
    test_random_stream(RANDOM_ITEMS / 2);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
